// ----- hdl/prrcq_pkg.sv -----
// Package for the priority round-robin class queues.
// Holds sizes, operation and queue codes, and address helpers.
// Used by the top module, the checker and the testbench.
package prrcq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int TYPE_COUNT  = 256;
    localparam int NUM_QUEUES  = 5;

    localparam int PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int ITEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ITEM_AW    = $clog2(ITEM_DEPTH);
    localparam int CNT_DEPTH  = 3 * TYPE_COUNT;
    localparam int CNT_AW     = $clog2(CNT_DEPTH);
    localparam int WORD_W     = 26;
    localparam int COUNT_W    = 9;
    localparam int IN_W       = 32;
    localparam int OUT_W      = 48;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP        = 3'd2,
        OP_QUERY      = 3'd3,
        OP_CLEAR      = 3'd4
    } op_t;

    localparam logic [2:0] Q_URGENT   = 3'd0;
    localparam logic [2:0] Q_BUILDING = 3'd1;
    localparam logic [2:0] Q_ARMY     = 3'd2;
    localparam logic [2:0] Q_WORKER   = 3'd3;
    localparam logic [2:0] Q_TECH     = 3'd4;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_UNIT = 2'd1;
    localparam logic [1:0] RR_RESET  = 2'd3;

    function automatic logic cnt_hit(input logic [1:0] kind, input logic [7:0] type_id);
        return (kind != KIND_NONE) && (int'(type_id) < TYPE_COUNT);
    endfunction

    function automatic logic [CNT_AW-1:0] cnt_index(input logic [1:0] kind,
                                                    input logic [7:0] type_id);
        int idx;
        idx = (int'(kind) - 1) * TYPE_COUNT + int'(type_id);
        return CNT_AW'(idx);
    endfunction

    function automatic logic [ITEM_AW-1:0] item_index(input logic [2:0] q,
                                                      input logic [PTR_W-1:0] pos);
        int idx;
        idx = int'(q) * QUEUE_DEPTH + int'(pos);
        return ITEM_AW'(idx);
    endfunction

endpackage

// ----- hdl/prrcq_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module prrcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/priority_round_robin_class_queues_top.sv -----
// Priority round-robin class queues: sequencer, queue pointers and both memories.
// Depends on prrcq_pkg and prrcq_ram.
//
// The block keeps five deques (urgent plus four class queues) in one item RAM
// and the per-kind, per-type counts in one count RAM, both with a registered
// read port. Each item produces exactly one result. A push without a counted
// type, a dropped push, an empty pop, a query of kind none and unused codes go
// from accept straight to S_DONE; a counted push, a counted query and a pop of
// an item of kind none pass through S_MEM (one extra RAM access); a pop of a
// counted item passes through S_MEM and S_CNT, as the item RAM read must land
// before its count can be read and decremented. The block then waits for the
// result register to free before taking the next item. After reset and after
// each clear, S_CLR zeroes all 768 (3*TYPE_COUNT) count entries; no item is accepted meanwhile.
module priority_round_robin_class_queues_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // operation[2:0], item_kind[4:3], type_id[12:5], urgent[13], is_building[14],
    // is_worker[15], item_tag[31:16]
    input  logic [prrcq_pkg::IN_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // item_valid[0], out_kind[2:1], out_type_id[10:3], out_tag[26:11],
    // served_queue[29:27], type_count[38:30], all_empty[39], push_dropped[40],
    // zero[47:41]
    output logic [prrcq_pkg::OUT_W-1:0] m_tdata
);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_MEM,
        S_CNT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [prrcq_pkg::PTR_W-1:0]   head_reg [prrcq_pkg::NUM_QUEUES];
    logic [prrcq_pkg::PTR_W-1:0]   head_next [prrcq_pkg::NUM_QUEUES];
    logic [prrcq_pkg::FILL_W-1:0]  fill_reg [prrcq_pkg::NUM_QUEUES];
    logic [prrcq_pkg::FILL_W-1:0]  fill_next [prrcq_pkg::NUM_QUEUES];
    logic [1:0]                    rr_reg, rr_next;
    logic [2:0]                    op_reg, op_next;
    logic [prrcq_pkg::CNT_AW-1:0]  caddr_reg, caddr_next;
    logic [prrcq_pkg::CNT_AW-1:0]  clr_reg, clr_next;
    logic                          clr_op_reg, clr_op_next;

    logic                          res_valid_reg, res_valid_next;
    logic [1:0]                    res_kind_reg, res_kind_next;
    logic [7:0]                    res_type_reg, res_type_next;
    logic [15:0]                   res_tag_reg, res_tag_next;
    logic [2:0]                    res_q_reg, res_q_next;
    logic [prrcq_pkg::COUNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic                          res_drop_reg, res_drop_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [prrcq_pkg::OUT_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                          item_we;
    logic [prrcq_pkg::ITEM_AW-1:0] item_waddr, item_raddr;
    logic [prrcq_pkg::WORD_W-1:0]  item_wdata, item_rdata;
    logic                          cnt_we;
    logic [prrcq_pkg::CNT_AW-1:0]  cnt_waddr, cnt_raddr;
    logic [prrcq_pkg::COUNT_W-1:0] cnt_wdata, cnt_rdata;

    logic [2:0]  in_op;
    logic [1:0]  in_kind;
    logic [7:0]  in_type;
    logic        in_urgent, in_building, in_worker;
    logic [15:0] in_tag;
    logic        all_empty;

    assign in_op       = s_tdata[2:0];
    assign in_kind     = s_tdata[4:3];
    assign in_type     = s_tdata[12:5];
    assign in_urgent   = s_tdata[13];
    assign in_building = s_tdata[14];
    assign in_worker   = s_tdata[15];
    assign in_tag      = s_tdata[31:16];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        all_empty = 1'b1;
        for (int i = 0; i < prrcq_pkg::NUM_QUEUES; i++)
        begin
            if (fill_reg[i] != '0)
            begin
                all_empty = 1'b0;
            end
        end
    end

    prrcq_ram #(
        .WIDTH (prrcq_pkg::WORD_W),
        .DEPTH (prrcq_pkg::ITEM_DEPTH)
    ) u_item_ram (
        .clk   (clk),
        .we    (item_we),
        .waddr (item_waddr),
        .wdata (item_wdata),
        .raddr (item_raddr),
        .rdata (item_rdata)
    );

    prrcq_ram #(
        .WIDTH (prrcq_pkg::COUNT_W),
        .DEPTH (prrcq_pkg::CNT_DEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    always_comb
    begin
        logic [2:0]                   q;
        logic [prrcq_pkg::PTR_W-1:0]  pos;
        logic [prrcq_pkg::PTR_W-1:0]  hd;
        logic [1:0]                   rr_adv;
        int                           sum;

        state_next    = state_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        rr_next       = rr_reg;
        op_next       = op_reg;
        caddr_next    = caddr_reg;
        clr_next      = clr_reg;
        clr_op_next   = clr_op_reg;
        res_valid_next = res_valid_reg;
        res_kind_next = res_kind_reg;
        res_type_next = res_type_reg;
        res_tag_next  = res_tag_reg;
        res_q_next    = res_q_reg;
        res_cnt_next  = res_cnt_reg;
        res_drop_next = res_drop_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        item_we    = 1'b0;
        item_waddr = '0;
        item_wdata = {in_kind, in_type, in_tag};
        item_raddr = '0;
        cnt_we     = 1'b0;
        cnt_waddr  = caddr_reg;
        cnt_wdata  = '0;
        cnt_raddr  = caddr_reg;

        q      = prrcq_pkg::Q_URGENT;
        pos    = '0;
        hd     = '0;
        rr_adv = rr_reg + 2'd1;
        sum    = 0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_CLR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (int'(clr_reg) == prrcq_pkg::CNT_DEPTH - 1)
                begin
                    clr_next   = '0;
                    state_next = clr_op_reg ? S_DONE : S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next        = in_op;
                    res_valid_next = 1'b0;
                    res_kind_next  = '0;
                    res_type_next  = '0;
                    res_tag_next   = '0;
                    res_q_next     = prrcq_pkg::Q_URGENT;
                    res_cnt_next   = '0;
                    res_drop_next  = 1'b0;
                    caddr_next     = prrcq_pkg::cnt_index(in_kind, in_type);
                    cnt_raddr      = prrcq_pkg::cnt_index(in_kind, in_type);
                    state_next     = S_DONE;
                    case (in_op)
                        prrcq_pkg::OP_PUSH_BACK, prrcq_pkg::OP_PUSH_FRONT:
                        begin
                            if (in_urgent)
                                q = prrcq_pkg::Q_URGENT;
                            else if (in_building)
                                q = prrcq_pkg::Q_BUILDING;
                            else if (in_worker)
                                q = prrcq_pkg::Q_WORKER;
                            else if (in_kind == prrcq_pkg::KIND_UNIT)
                                q = prrcq_pkg::Q_ARMY;
                            else
                                q = prrcq_pkg::Q_TECH;
                            if (int'(fill_reg[q]) >= prrcq_pkg::QUEUE_DEPTH)
                            begin
                                res_drop_next = 1'b1;
                            end
                            else
                            begin
                                if (in_op == prrcq_pkg::OP_PUSH_BACK)
                                begin
                                    sum = int'(head_reg[q]) + int'(fill_reg[q]);
                                    if (sum >= prrcq_pkg::QUEUE_DEPTH)
                                    begin
                                        sum = sum - prrcq_pkg::QUEUE_DEPTH;
                                    end
                                    pos = prrcq_pkg::PTR_W'(sum);
                                end
                                else
                                begin
                                    if (head_reg[q] == '0)
                                        pos = prrcq_pkg::PTR_W'(prrcq_pkg::QUEUE_DEPTH - 1);
                                    else
                                        pos = head_reg[q] - 1'b1;
                                    head_next[q] = pos;
                                end
                                item_we      = 1'b1;
                                item_waddr   = prrcq_pkg::item_index(q, pos);
                                fill_next[q] = fill_reg[q] + 1'b1;
                                if (prrcq_pkg::cnt_hit(in_kind, in_type))
                                begin
                                    state_next = S_MEM;
                                end
                            end
                        end
                        prrcq_pkg::OP_POP:
                        begin
                            if (fill_reg[prrcq_pkg::Q_URGENT] != '0)
                            begin
                                q = prrcq_pkg::Q_URGENT;
                            end
                            else
                            begin
                                rr_next = rr_adv;
                                q       = {1'b0, rr_adv} + 3'd1;
                            end
                            res_q_next = q;
                            if (fill_reg[q] != '0)
                            begin
                                item_raddr = prrcq_pkg::item_index(q, head_reg[q]);
                                if (int'(head_reg[q]) == prrcq_pkg::QUEUE_DEPTH - 1)
                                    hd = '0;
                                else
                                    hd = head_reg[q] + 1'b1;
                                head_next[q] = hd;
                                fill_next[q] = fill_reg[q] - 1'b1;
                                state_next   = S_MEM;
                            end
                        end
                        prrcq_pkg::OP_QUERY:
                        begin
                            if (prrcq_pkg::cnt_hit(in_kind, in_type))
                            begin
                                state_next = S_MEM;
                            end
                        end
                        prrcq_pkg::OP_CLEAR:
                        begin
                            for (int i = 0; i < prrcq_pkg::NUM_QUEUES; i++)
                            begin
                                head_next[i] = '0;
                                fill_next[i] = '0;
                            end
                            rr_next     = prrcq_pkg::RR_RESET;
                            clr_next    = '0;
                            clr_op_next = 1'b1;
                            state_next  = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_MEM:
            begin
                state_next = S_DONE;
                case (op_reg)
                    prrcq_pkg::OP_POP:
                    begin
                        res_valid_next = 1'b1;
                        res_kind_next  = item_rdata[25:24];
                        res_type_next  = item_rdata[23:16];
                        res_tag_next   = item_rdata[15:0];
                        caddr_next     = prrcq_pkg::cnt_index(item_rdata[25:24],
                                                              item_rdata[23:16]);
                        cnt_raddr      = caddr_next;
                        if (prrcq_pkg::cnt_hit(item_rdata[25:24], item_rdata[23:16]))
                        begin
                            state_next = S_CNT;
                        end
                    end
                    prrcq_pkg::OP_QUERY:
                    begin
                        res_cnt_next = cnt_rdata;
                    end
                    default:
                    begin
                        // counted push: saturating increment
                        cnt_we    = 1'b1;
                        cnt_wdata = (cnt_rdata == prrcq_pkg::COUNT_MAX) ?
                                    cnt_rdata : cnt_rdata + 1'b1;
                    end
                endcase
            end

            S_CNT:
            begin
                cnt_we     = 1'b1;
                cnt_wdata  = (cnt_rdata == '0) ? cnt_rdata : cnt_rdata - 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // hold the result until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, res_drop_reg, all_empty, res_cnt_reg,
                                     res_q_reg, res_tag_reg, res_type_reg,
                                     res_kind_reg, res_valid_reg};
                    clr_op_next   = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            for (int i = 0; i < prrcq_pkg::NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            rr_reg       <= prrcq_pkg::RR_RESET;
            clr_reg      <= '0;
            clr_op_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            fill_reg     <= fill_next;
            rr_reg       <= rr_next;
            clr_reg      <= clr_next;
            clr_op_reg   <= clr_op_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        caddr_reg     <= caddr_next;
        res_valid_reg <= res_valid_next;
        res_kind_reg  <= res_kind_next;
        res_type_reg  <= res_type_next;
        res_tag_reg   <= res_tag_next;
        res_q_reg     <= res_q_next;
        res_cnt_reg   <= res_cnt_next;
        res_drop_reg  <= res_drop_next;
        m_tdata_reg   <= m_tdata_next;
    end

endmodule

// ----- hdl/prrcq_checker.sv -----
// Port-level checks for the priority round-robin class queues.
// Depends on prrcq_pkg; bound to priority_round_robin_class_queues_top.
module prrcq_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [prrcq_pkg::IN_W-1:0]  s_tdata,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [prrcq_pkg::OUT_W-1:0] m_tdata
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // a popped item is never reported together with a dropped push or a count
    a_pop_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> !m_tdata[40] && m_tdata[38:30] == '0)
        else $error("popped item mixed with other result fields");

    // a null item carries no kind, type or tag
    a_null_item: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[26:1] == '0)
        else $error("null item with payload");

    // served queue code is in range and the padding bits stay zero
    a_queue_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[29:27] <= 3'd4 && m_tdata[47:41] == '0)
        else $error("bad served queue code or padding");

    // no two items are accepted back to back while a result sits stalled
    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !(m_tvalid && !m_tready && $past(m_tvalid)
                                   && $past(s_tready) && $past(s_tvalid)))
        else $error("item accepted back to back under stall");

endmodule

bind priority_round_robin_class_queues_top prrcq_checker u_prrcq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/sv/tb_priority_round_robin_class_queues_top.sv -----
// Testbench for the priority round-robin class queues block.
// Drives a directed table and random traffic; checks every result by local predictor or row.
// Depends on prrcq_pkg and priority_round_robin_class_queues_top.
module tb_priority_round_robin_class_queues_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 1030;
    localparam int EXP_DEPTH = 4096;
    localparam int MAX_ROWS = 64;

    typedef struct packed {
        logic [15:0] tag;
        logic        worker;
        logic        building;
        logic        urgent;
        logic [7:0]  type_id;
        logic [1:0]  kind;
        logic [2:0]  op;
    } cmd_t;

    typedef struct packed {
        logic [6:0]  zero;
        logic        dropped;
        logic        empty;
        logic [8:0]  count;
        logic [2:0]  served;
        logic [15:0] tag;
        logic [7:0]  type_id;
        logic [1:0]  kind;
        logic        valid;
    } res_t;

    typedef struct {
        cmd_t c;
        bit   typed;
        res_t r;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [prrcq_pkg::IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [prrcq_pkg::OUT_W-1:0] m_tdata;

    priority_round_robin_class_queues_top u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    logic [25:0] q_mem [prrcq_pkg::NUM_QUEUES][prrcq_pkg::QUEUE_DEPTH];
    int unsigned q_head [prrcq_pkg::NUM_QUEUES];
    int unsigned q_fill [prrcq_pkg::NUM_QUEUES];
    int unsigned type_cnt [4][prrcq_pkg::TYPE_COUNT];
    logic [1:0] rr;

    // expected results, written at input accept and read at output accept
    res_t exp_fifo [EXP_DEPTH];
    int exp_wr = 0;
    int exp_rd = 0;
    int errors = 0;
    bit hold_off = 0;
    int idle_cycles = 0;

    function automatic void expect_put(res_t r);
        exp_fifo[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endfunction

    function automatic res_t expect_take();
        res_t r;
        r = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        return r;
    endfunction

    function automatic void clear_queues();
        for (int q = 0; q < prrcq_pkg::NUM_QUEUES; q++)
        begin
            q_head[q] = 0;
            q_fill[q] = 0;
        end
        for (int k = 0; k < 4; k++)
            for (int t = 0; t < prrcq_pkg::TYPE_COUNT; t++)
                type_cnt[k][t] = 0;
        rr = prrcq_pkg::RR_RESET;
    endfunction

    function automatic res_t predict_queues(cmd_t c);
        res_t r;
        int q;
        int pos;
        logic [25:0] w;
        r = '0;
        if (c.op == prrcq_pkg::OP_PUSH_BACK || c.op == prrcq_pkg::OP_PUSH_FRONT)
        begin
            if (c.urgent) q = prrcq_pkg::Q_URGENT;
            else if (c.building) q = prrcq_pkg::Q_BUILDING;
            else if (c.worker) q = prrcq_pkg::Q_WORKER;
            else if (c.kind == prrcq_pkg::KIND_UNIT) q = prrcq_pkg::Q_ARMY;
            else q = prrcq_pkg::Q_TECH;
            if (q_fill[q] >= prrcq_pkg::QUEUE_DEPTH)
                r.dropped = 1'b1;
            else
            begin
                if (c.op == prrcq_pkg::OP_PUSH_BACK)
                    pos = (q_head[q] + q_fill[q]) % prrcq_pkg::QUEUE_DEPTH;
                else
                begin
                    pos = (q_head[q] + prrcq_pkg::QUEUE_DEPTH - 1) % prrcq_pkg::QUEUE_DEPTH;
                    q_head[q] = pos;
                end
                q_mem[q][pos] = {c.kind, c.type_id, c.tag};
                q_fill[q]++;
                if (c.kind != prrcq_pkg::KIND_NONE && type_cnt[c.kind][c.type_id] < 511)
                    type_cnt[c.kind][c.type_id]++;
            end
        end
        else if (c.op == prrcq_pkg::OP_POP)
        begin
            if (q_fill[prrcq_pkg::Q_URGENT] != 0)
                q = prrcq_pkg::Q_URGENT;
            else
            begin
                rr = rr + 2'd1;
                q = int'(rr) + 1;
            end
            r.served = 3'(q);
            if (q_fill[q] != 0)
            begin
                w = q_mem[q][q_head[q]];
                q_head[q] = (q_head[q] + 1) % prrcq_pkg::QUEUE_DEPTH;
                q_fill[q]--;
                r.valid = 1'b1;
                r.kind = w[25:24];
                r.type_id = w[23:16];
                r.tag = w[15:0];
                if (r.kind != prrcq_pkg::KIND_NONE && type_cnt[r.kind][r.type_id] > 0)
                    type_cnt[r.kind][r.type_id]--;
            end
        end
        else if (c.op == prrcq_pkg::OP_QUERY)
        begin
            if (c.kind != prrcq_pkg::KIND_NONE)
                r.count = 9'(type_cnt[c.kind][c.type_id]);
        end
        else if (c.op == prrcq_pkg::OP_CLEAR)
            clear_queues();
        r.empty = 1'b1;
        for (int i = 0; i < prrcq_pkg::NUM_QUEUES; i++)
            if (q_fill[i] != 0) r.empty = 1'b0;
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int sel;
        c = cmd_t'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 45)
            c.op = ($urandom_range(0, 1) == 0) ? prrcq_pkg::OP_PUSH_BACK
                                               : prrcq_pkg::OP_PUSH_FRONT;
        else if (sel < 80) c.op = prrcq_pkg::OP_POP;
        else if (sel < 96) c.op = prrcq_pkg::OP_QUERY;
        else if (sel < 98) c.op = prrcq_pkg::OP_CLEAR;
        else c.op = 3'($urandom_range(5, 7));
        // keep types few so counts build up and queries hit
        if ($urandom_range(0, 3) != 0) c.type_id = 8'($urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0) c.urgent = 1'b0;
        return c;
    endfunction

    // leaves tvalid high after the accept; the next call reloads or drops it, the end drops it
    task automatic send_item(cmd_t c);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expect_put(predict_queues(c));
    endtask

    function automatic cmd_t mk(logic [2:0] op, logic [1:0] k, logic [7:0] t, logic u,
                                logic b, logic w, logic [15:0] g);
        cmd_t c;
        c.op = op; c.kind = k; c.type_id = t; c.urgent = u;
        c.building = b; c.worker = w; c.tag = g;
        return c;
    endfunction

    // receiver
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_off = 0;
            end
            g = gap_len();
            if (g > 0)
            begin
                m_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // checker
    always @(posedge clk)
    begin
        res_t a;
        res_t e;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (m_tvalid && m_tready)
        begin
            a = res_t'(m_tdata);
            if (exp_wr == exp_rd)
            begin
                $display("%0t: unexpected result %h", $time, a);
                errors++;
            end
            else
            begin
                e = expect_take();
                if (a !== e)
                begin
                    $display("%0t: expected %h actual %h", $time, e, a);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    row_t rows [MAX_ROWS];
    int n_rows = 0;

    function automatic void append_row(row_t r);
        rows[n_rows] = r;
        n_rows++;
    endfunction

    initial
    begin
        row_t row;
        res_t z;
        int drain;
        rst_n <= 1'b0;
        clear_queues();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        z = '0;
        // after reset: empty pops walk building, army, worker, tech
        row.c = mk(prrcq_pkg::OP_POP, 0, 0, 0, 0, 0, 0); row.typed = 1;
        row.r = z; row.r.served = prrcq_pkg::Q_BUILDING; row.r.empty = 1; append_row(row);
        row.r.served = prrcq_pkg::Q_ARMY; append_row(row);
        row.r.served = prrcq_pkg::Q_WORKER; append_row(row);
        row.r.served = prrcq_pkg::Q_TECH; append_row(row);
        row.c = mk(prrcq_pkg::OP_QUERY, 3, 255, 0, 0, 0, 0); row.r = z; row.r.empty = 1;
        append_row(row);
        row.c = mk(3'd7, 3, 255, 1, 1, 1, 16'hffff); append_row(row);
        row.c = mk(3'd5, 0, 0, 0, 0, 0, 0); append_row(row);
        row.typed = 0;
        row.c = mk(prrcq_pkg::OP_PUSH_BACK, 1, 255, 0, 0, 0, 16'hffff); append_row(row);
        row.c = mk(prrcq_pkg::OP_PUSH_FRONT, 1, 255, 0, 0, 0, 16'h0000); append_row(row);
        row.c = mk(prrcq_pkg::OP_PUSH_BACK, 0, 7, 0, 1, 0, 16'h1234); append_row(row);
        row.c = mk(prrcq_pkg::OP_PUSH_BACK, 2, 0, 0, 0, 1, 16'h5555); append_row(row);
        row.c = mk(prrcq_pkg::OP_PUSH_BACK, 3, 9, 0, 0, 0, 16'haaaa); append_row(row);
        row.c = mk(prrcq_pkg::OP_PUSH_BACK, 2, 9, 1, 1, 1, 16'h8001); append_row(row);
        row.c = mk(prrcq_pkg::OP_QUERY, 1, 255, 0, 0, 0, 0); append_row(row);
        row.c = mk(prrcq_pkg::OP_QUERY, 0, 7, 0, 0, 0, 0); append_row(row);
        for (int i = 0; i < 6; i++)
        begin
            row.c = mk(prrcq_pkg::OP_POP, 0, 0, 0, 0, 0, 0); append_row(row);
        end
        row.c = mk(prrcq_pkg::OP_QUERY, 1, 255, 0, 0, 0, 0); append_row(row);
        row.c = mk(prrcq_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0); append_row(row);
        row.c = mk(prrcq_pkg::OP_POP, 0, 0, 0, 0, 0, 0); row.typed = 1;
        row.r = z; row.r.served = prrcq_pkg::Q_BUILDING; row.r.empty = 1; append_row(row);

        for (int i = 0; i < n_rows; i++)
        begin
            send_item(rows[i].c);
            if (rows[i].typed)
                exp_fifo[(exp_wr - 1) % EXP_DEPTH] = rows[i].r;
        end

        // fill one queue past full with a stalled receiver
        hold_off = 1;
        for (int i = 0; i < 70; i++)
            send_item(mk(prrcq_pkg::OP_PUSH_BACK, 3, 8'(i % 3), 1, 0, 0, 16'(i)));
        for (int i = 0; i < 3; i++)
            send_item(mk(prrcq_pkg::OP_QUERY, 3, 8'(i), 0, 0, 0, 0));
        for (int i = 0; i < 72; i++)
            send_item(mk(prrcq_pkg::OP_POP, 0, 0, 0, 0, 0, 0));

        for (int i = 0; i < N_RANDOM; i++)
            send_item(random_cmd());
        s_tvalid <= 1'b0;

        drain = 0;
        while (exp_wr != exp_rd && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && exp_wr == exp_rd)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ----- files.f -----
hdl/prrcq_pkg.sv
hdl/prrcq_ram.sv
hdl/priority_round_robin_class_queues_top.sv
hdl/prrcq_checker.sv
tb/sv/tb_priority_round_robin_class_queues_top.sv
